[rtl/intel_hex_record_parser_macros.svh]
// Assertion macros used by the checker of the hex record parser.
`ifndef INTEL_HEX_RECORD_PARSER_MACROS_SVH
`define INTEL_HEX_RECORD_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define IHEX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define IHEX_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ihex_pkg.sv]
`default_nettype none

package ihex_pkg;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_COUNT  = 3'd1,
    PH_OFF_HI = 3'd2,
    PH_OFF_LO = 3'd3,
    PH_TYPE   = 3'd4,
    PH_DATA   = 3'd5,
    PH_CSUM   = 3'd6
  } phase_t;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_DATA     = 3'd0;
  localparam kind_t KIND_OK       = 3'd1;
  localparam kind_t KIND_CSUM_ERR = 3'd2;
  localparam kind_t KIND_EOF      = 3'd3;
  localparam kind_t KIND_FORMAT   = 3'd4;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] REC_DATA   = 8'h00;
  localparam logic [7:0] REC_EOF    = 8'h01;
  localparam logic [7:0] REC_ULBA   = 8'h04;

  // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/intel_hex_record_parser.sv]
// Results are registered in the output entry, or in the skid entry while it is held.
// Throughput: one character per cycle while in_stall is low; all decoding fits between
// the parser state and the output register.
// A two-entry output stage lets characters keep flowing while a result waits;
// in_stall rises only when both entries are full.
// Synchronous active-low reset returns the parser to waiting for a colon, clears the base.
`default_nettype none

module intel_hex_record_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          in_char_in,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ihex_pkg::kind_t          out_kind,
  output logic [31:0]              out_byte_address,
  output logic [7:0]               out_byte_value,
  output logic [7:0]               out_rec_type
);
  import ihex_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  high_nibble_r, high_nibble_nxt;
  logic        nibble_pos_r, nibble_pos_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [15:0] offset_r, offset_nxt;
  logic [7:0]  record_kind_r, record_kind_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [7:0]  byte_index_r, byte_index_nxt;
  logic [15:0] upper_base_r, upper_base_nxt;
  logic [15:0] pending_upper_r, pending_upper_nxt;
  logic        finished_r, finished_nxt;

  logic        accept;
  logic        start_rec;
  logic [4:0]  hv;
  logic [7:0]  byte_v;
  logic [7:0]  sum_v;
  logic [7:0]  index_inc;

  logic        res_valid;
  kind_t       res_kind;
  logic [31:0] res_addr;
  logic [7:0]  res_value;
  logic [7:0]  res_type;

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  logic        out_load, skid_load, out_from_skid;
  kind_t       out_kind_r, skid_kind_r;
  logic [31:0] out_addr_r, skid_addr_r;
  logic [7:0]  out_value_r, skid_value_r;
  logic [7:0]  out_type_r, skid_type_r;

  assign accept    = in_valid & ~in_stall;
  assign hv        = hex_decode(in_char_in);
  assign byte_v    = {high_nibble_r, hv[3:0]};
  assign sum_v     = running_sum_r + byte_v;
  assign index_inc = byte_index_r + 8'd1;

  always_comb begin
    phase_nxt         = phase_r;
    high_nibble_nxt   = high_nibble_r;
    nibble_pos_nxt    = nibble_pos_r;
    count_nxt         = count_r;
    offset_nxt        = offset_r;
    record_kind_nxt   = record_kind_r;
    running_sum_nxt   = running_sum_r;
    byte_index_nxt    = byte_index_r;
    upper_base_nxt    = upper_base_r;
    pending_upper_nxt = pending_upper_r;
    finished_nxt      = finished_r;
    start_rec         = 1'b0;
    res_valid         = 1'b0;
    res_kind          = KIND_DATA;
    res_addr          = 32'd0;
    res_value         = 8'd0;
    res_type          = 8'd0;

    if (accept && !finished_r) begin
      if (phase_r == PH_WAIT) begin
        start_rec = (in_char_in == CHAR_COLON);
      end else if (!hv[4]) begin
        res_valid = 1'b1;
        res_kind  = KIND_FORMAT;
        res_type  = record_kind_r;
        if (in_char_in == CHAR_COLON) begin
          start_rec = 1'b1;
        end else begin
          phase_nxt = PH_WAIT;
        end
      end else if (!nibble_pos_r) begin
        high_nibble_nxt = hv[3:0];
        nibble_pos_nxt  = 1'b1;
      end else begin
        nibble_pos_nxt  = 1'b0;
        running_sum_nxt = sum_v;
        case (phase_r)
          PH_COUNT: begin
            count_nxt = byte_v;
            phase_nxt = PH_OFF_HI;
          end
          PH_OFF_HI: begin
            offset_nxt = {byte_v, 8'h00};
            phase_nxt  = PH_OFF_LO;
          end
          PH_OFF_LO: begin
            offset_nxt = {offset_r[15:8], byte_v};
            phase_nxt  = PH_TYPE;
          end
          PH_TYPE: begin
            record_kind_nxt = byte_v;
            byte_index_nxt  = 8'd0;
            phase_nxt       = (count_r != 8'd0) ? PH_DATA : PH_CSUM;
          end
          PH_DATA: begin
            if (record_kind_r == REC_DATA) begin
              res_valid = 1'b1;
              res_kind  = KIND_DATA;
              res_addr  = {upper_base_r, 16'h0000} + {16'h0000, offset_r}
                          + {24'h000000, byte_index_r};
              res_value = byte_v;
            end else if (record_kind_r == REC_ULBA) begin
              if (byte_index_r == 8'd0) begin
                pending_upper_nxt = {byte_v, 8'h00};
              end else if (byte_index_r == 8'd1) begin
                pending_upper_nxt = {pending_upper_r[15:8], byte_v};
              end
            end
            byte_index_nxt = index_inc;
            if (index_inc == count_r) begin
              phase_nxt = PH_CSUM;
            end
          end
          PH_CSUM: begin
            phase_nxt = PH_WAIT;
            res_valid = 1'b1;
            res_type  = record_kind_r;
            if (sum_v != 8'd0) begin
              res_kind = KIND_CSUM_ERR;
            end else if (record_kind_r == REC_EOF) begin
              finished_nxt = 1'b1;
              res_kind     = KIND_EOF;
            end else begin
              if (record_kind_r == REC_ULBA) begin
                upper_base_nxt = pending_upper_r;
              end
              res_kind = KIND_OK;
            end
          end
          default: begin
            phase_nxt = PH_WAIT;
          end
        endcase
      end

      if (start_rec) begin
        phase_nxt         = PH_COUNT;
        high_nibble_nxt   = 4'd0;
        nibble_pos_nxt    = 1'b0;
        count_nxt         = 8'd0;
        offset_nxt        = 16'd0;
        record_kind_nxt   = 8'd0;
        running_sum_nxt   = 8'd0;
        byte_index_nxt    = 8'd0;
        pending_upper_nxt = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_WAIT;
      high_nibble_r   <= 4'd0;
      nibble_pos_r    <= 1'b0;
      count_r         <= 8'd0;
      offset_r        <= 16'd0;
      record_kind_r   <= 8'd0;
      running_sum_r   <= 8'd0;
      byte_index_r    <= 8'd0;
      upper_base_r    <= 16'd0;
      pending_upper_r <= 16'd0;
      finished_r      <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      high_nibble_r   <= high_nibble_nxt;
      nibble_pos_r    <= nibble_pos_nxt;
      count_r         <= count_nxt;
      offset_r        <= offset_nxt;
      record_kind_r   <= record_kind_nxt;
      running_sum_r   <= running_sum_nxt;
      byte_index_r    <= byte_index_nxt;
      upper_base_r    <= upper_base_nxt;
      pending_upper_r <= pending_upper_nxt;
      finished_r      <= finished_nxt;
    end
  end

  // The skid entry fills only while the output entry is held, and it drains first.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_load       = 1'b0;
    out_from_skid  = 1'b0;
    skid_load      = 1'b0;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_load       = 1'b1;
        out_from_skid  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_load      = res_valid;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_load      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (out_from_skid) begin
        out_kind_r  <= skid_kind_r;
        out_addr_r  <= skid_addr_r;
        out_value_r <= skid_value_r;
        out_type_r  <= skid_type_r;
      end else begin
        out_kind_r  <= res_kind;
        out_addr_r  <= res_addr;
        out_value_r <= res_value;
        out_type_r  <= res_type;
      end
    end
    if (skid_load) begin
      skid_kind_r  <= res_kind;
      skid_addr_r  <= res_addr;
      skid_value_r <= res_value;
      skid_type_r  <= res_type;
    end
  end

  assign in_stall         = skid_valid_r;
  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_byte_address = out_addr_r;
  assign out_byte_value   = out_value_r;
  assign out_rec_type     = out_type_r;

endmodule

`default_nettype wire

[rtl/ihex_checker.sv]
`default_nettype none

`include "intel_hex_record_parser_macros.svh"

module ihex_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire ihex_pkg::kind_t     out_kind,
  input wire logic [31:0]         out_byte_address,
  input wire logic [7:0]          out_byte_value,
  input wire logic [7:0]          out_rec_type
);
  import ihex_pkg::*;

  logic        held;
  logic        is_data;
  logic        is_eof;
  logic        status;
  logic [50:0] word;
  logic [39:0] payload;

  assign held    = out_valid & out_stall;
  assign is_data = out_valid & (out_kind == KIND_DATA);
  assign is_eof  = out_valid & (out_kind == KIND_EOF);
  assign status  = out_valid & (out_kind != KIND_DATA);
  assign word    = {out_kind, out_byte_address, out_byte_value, out_rec_type};
  assign payload = {out_byte_address, out_byte_value};

  `IHEX_ASSERT_NXT(a_out_hold, held, out_valid && $stable(word), "stalled result word changed")
  `IHEX_ASSERT_IMP(a_data_type, is_data, out_rec_type == REC_DATA, "data byte with a record type")
  `IHEX_ASSERT_IMP(a_status_zero, status, payload == 40'd0, "status word not cleared")
  `IHEX_ASSERT_IMP(a_eof_type, is_eof, out_rec_type == REC_EOF, "end of file with wrong type")
  `IHEX_ASSERT_IMP(a_stall_full, in_stall, out_valid, "input stalled with no result held")

endmodule

bind intel_hex_record_parser ihex_checker u_ihex_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_kind         (out_kind),
  .out_byte_address (out_byte_address),
  .out_byte_value   (out_byte_value),
  .out_rec_type     (out_rec_type)
);

`default_nettype wire
